[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the CRC core.
// Each macro expands to one labeled concurrent assertion with a reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/pcrc_pkg.sv]
// ---------------------------------------------------------------------------
// pcrc_pkg
// Types, register codes and the long-division step of the CRC core.
// ---------------------------------------------------------------------------
package pcrc_pkg;

    // Remainder field width and the width of a remainder bit count.
    localparam int REM_W           = 31;
    localparam int RBITS_W         = 5;
    // Zero-append division steps done by one pipeline stage.
    localparam int STEPS_PER_STAGE = 8;

    // Transaction commands.
    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_GEN_POLY = 1'b0,
        REG_GEN_LEN  = 1'b1
    } t_reg_idx;

    localparam logic [31:0] GEN_POLY_RST = 32'd11;
    localparam logic [5:0]  GEN_LEN_RST  = 6'd4;

    // Input transaction payload.
    typedef struct packed {
        logic command;
        logic data_bit;
        logic last;
    } t_crc_in;

    // Result transaction payload.
    typedef struct packed {
        logic [REM_W-1:0] remainder;
        logic             error_found;
    } t_crc_out;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [RBITS_W-1:0] rem_bits;
        logic [REM_W-1:0]   poly;
    } t_crc_cfg;

    // Item carried through the zero-append pipeline.
    typedef struct packed {
        logic             command;
        logic [REM_W-1:0] rem;
    } t_zitem;

    // Mask of the low rem_bits bits (rem_bits from 1 to 31).
    function automatic logic [REM_W-1:0] rem_mask(input logic [RBITS_W-1:0] rem_bits);
        rem_mask = (REM_W'(1) << rem_bits) - REM_W'(1);
    endfunction

    // One long-division step: shift in a bit and subtract the generator
    // when the bit leaving the top of the remainder is one.
    function automatic logic [REM_W-1:0] div_step(
        input logic [REM_W-1:0]   rem,
        input logic               in_bit,
        input logic [RBITS_W-1:0] rem_bits,
        input logic [REM_W-1:0]   poly
    );
        logic [REM_W-1:0] mask;
        logic             top;
        logic [REM_W-1:0] nxt;
        mask = rem_mask(rem_bits);
        top  = rem[RBITS_W'(rem_bits - RBITS_W'(1))];
        nxt  = {rem[REM_W-2:0], in_bit} & mask;
        if (top) begin
            nxt = nxt ^ (poly & mask);
        end
        div_step = nxt;
    endfunction

endpackage

[src/pcrc_regs.sv]
// ---------------------------------------------------------------------------
// pcrc_regs
// APB register file for the generator polynomial and generator length.
// ---------------------------------------------------------------------------
module pcrc_regs
    import pcrc_pkg::*;
#(
    parameter int MAX_GEN_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_crc_cfg    o_cfg
);

    // Largest usable generator length: the remainder field holds 31 bits.
    localparam int LEN_CAP = (MAX_GEN_BITS > 32) ? 32 :
                             ((MAX_GEN_BITS < 2) ? 2 : MAX_GEN_BITS);

    logic [31:0] r_gen_poly;
    logic [5:0]  r_gen_len;
    t_reg_idx    reg_idx;
    logic        wr_en;
    logic [5:0]  len_sat;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_poly <= GEN_POLY_RST;
            r_gen_len  <= GEN_LEN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GEN_POLY: r_gen_poly <= pwdata;
                REG_GEN_LEN:  r_gen_len  <= pwdata[5:0];
                default:      r_gen_poly <= r_gen_poly;
            endcase
        end
    end

    // Read data.
    always_comb begin
        unique case (reg_idx)
            REG_GEN_POLY: prdata = r_gen_poly;
            REG_GEN_LEN:  prdata = {26'd0, r_gen_len};
            default:      prdata = 32'd0;
        endcase
    end

    // Saturate the generator length into the supported range.
    always_comb begin
        len_sat = r_gen_len;
        if (len_sat > 6'(LEN_CAP)) begin
            len_sat = 6'(LEN_CAP);
        end
        if (len_sat < 6'd2) begin
            len_sat = 6'd2;
        end
    end

    assign o_cfg.rem_bits = RBITS_W'(len_sat - 6'd1);
    assign o_cfg.poly     = r_gen_poly[REM_W-1:0];

endmodule

[src/pcrc_front.sv]
// ---------------------------------------------------------------------------
// pcrc_front
// Running remainder: one division step per accepted bit, and a launch
// register that hands the remainder of a finished message to the
// zero-append pipeline.
// ---------------------------------------------------------------------------
module pcrc_front
    import pcrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_crc_cfg i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_crc_in  i_in,
    output logic     o_l_valid,
    input  logic     i_l_ready,
    output t_zitem   o_l_item
);

    logic [REM_W-1:0] r_run;
    logic             r_l_valid;
    t_zitem           r_l_item;
    logic [REM_W-1:0] n_run;
    logic             accept;

    // Bits that do not end a message never wait; the last bit needs the
    // launch slot to be free.
    assign o_in_ready = !i_in.last || !r_l_valid || i_l_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign n_run      = div_step(r_run, i_in.data_bit, i_cfg.rem_bits, i_cfg.poly);

    // Running remainder, cleared after the last bit of a message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (accept) begin
            r_run <= i_in.last ? '0 : n_run;
        end
    end

    // Launch register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else if (accept && i_in.last) begin
            r_l_valid <= 1'b1;
        end else if (i_l_ready) begin
            r_l_valid <= 1'b0;
        end
    end

    // Launch register payload.
    always_ff @(posedge i_clk) begin
        if (accept && i_in.last) begin
            r_l_item.command <= i_in.command;
            r_l_item.rem     <= n_run;
        end
    end

    assign o_l_valid = r_l_valid;
    assign o_l_item  = r_l_item;

endmodule

[src/pcrc_zstage.sv]
// ---------------------------------------------------------------------------
// pcrc_zstage
// One stage of the zero-append pipeline: a group of division steps with a
// zero bit shifted in, applied in generate mode while the step number is
// below the remainder width.
// ---------------------------------------------------------------------------
module pcrc_zstage
    import pcrc_pkg::*;
#(
    parameter int FIRST_STEP = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_crc_cfg i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_zitem   i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_zitem   o_item
);

    logic   r_valid;
    t_zitem r_item;
    t_zitem n_item;

    assign o_ready = !r_valid || i_ready;

    // Zero-append steps of this stage.
    always_comb begin
        n_item = i_item;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if ((i_item.command == CMD_GENERATE) &&
                ((FIRST_STEP + j) < int'(i_cfg.rem_bits))) begin
                n_item.rem = div_step(n_item.rem, 1'b0, i_cfg.rem_bits, i_cfg.poly);
            end
        end
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/programmable_crc_generate_check_core.sv]
// ---------------------------------------------------------------------------
// programmable_crc_generate_check_core
// Programmable CRC generator and checker taking one message bit per
// transaction, most significant bit first.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_ready      i_in  (t_crc_in)
//   result    out        o_out_valid / i_out_ready    o_out (t_crc_out)
//   config    in         psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// At most one input transaction is accepted per cycle; a last bit waits
// while the launch register is stalled. The running remainder takes one
// division step per accepted bit. The result of a message passes from
// the launch register through the zero-append stages, 8 steps a stage,
// and leaves the last stage, which is the result register.
// Reset clears the running remainder and all pipeline valids; no clearing
// pass is needed.
// A stalled result holds the pipeline; bits that do not end a message are
// still accepted while it is held.
// ---------------------------------------------------------------------------
module programmable_crc_generate_check_core
    import pcrc_pkg::*;
#(
    parameter int MAX_GEN_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_crc_in     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_crc_out    o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "assert_macros.svh"

    localparam int LEN_CAP    = (MAX_GEN_BITS > 32) ? 32 :
                                ((MAX_GEN_BITS < 2) ? 2 : MAX_GEN_BITS);
    localparam int NUM_STAGES = (LEN_CAP - 1 + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    t_crc_cfg         cfg;
    logic             s_valid [NUM_STAGES+1];
    logic             s_ready [NUM_STAGES+1];
    t_zitem           s_item  [NUM_STAGES+1];
    logic [REM_W-1:0] out_excess;
    logic             launch_stall;

    // Configuration registers.
    pcrc_regs #(
        .MAX_GEN_BITS(MAX_GEN_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Running remainder and launch register.
    pcrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_l_valid  (s_valid[0]),
        .i_l_ready  (s_ready[0]),
        .o_l_item   (s_item[0])
    );

    // Zero-append pipeline.
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_zstage
        pcrc_zstage #(
            .FIRST_STEP(k * STEPS_PER_STAGE)
        ) u_zstage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_item  (s_item[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_item  (s_item[k+1])
        );
    end

    // The last stage register is the result register.
    assign s_ready[NUM_STAGES] = i_out_ready;
    assign o_out_valid         = s_valid[NUM_STAGES];
    assign o_out.remainder     = s_item[NUM_STAGES].rem;
    assign o_out.error_found   = (s_item[NUM_STAGES].command == CMD_CHECK) &&
                                 (s_item[NUM_STAGES].rem != '0);

    // Helper terms for the assertions.
    assign out_excess   = o_out.remainder & ~rem_mask(cfg.rem_bits);
    assign launch_stall = s_valid[0] && !s_ready[0];

    // Assertions.
    `ASSERT_IMPLIES(a_rem_in_width, i_clk, i_rst_n, o_out_valid, out_excess == '0)
    `ASSERT_IMPLIES(a_ready_blocked, i_clk, i_rst_n, !o_in_ready, launch_stall && i_in.last)
    `ASSERT_NEXT(a_launch_holds, i_clk, i_rst_n, launch_stall, s_valid[0] && $stable(s_item[0]))

endmodule
